// ===== src/pinhole_point_projector_defines.svh =====
// ----------------------------------------------------------------------------
// pinhole_point_projector_defines
// Assertion macros shared by the projector RTL.
// ----------------------------------------------------------------------------
`ifndef PINHOLE_POINT_PROJECTOR_DEFINES_SVH
`define PINHOLE_POINT_PROJECTOR_DEFINES_SVH

// same-cycle implication
`define PPP_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// next-cycle implication
`define PPP_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ===== src/ppp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppp_pkg
// Types and constants of the pinhole point projector pipeline.
// ----------------------------------------------------------------------------
package ppp_pkg;

   localparam int NUM_CSR   = 6;
   localparam int DIV_STEPS = 33;   // quotient bits below the overflow check

   localparam logic [2:0] CSR_ROW0_C01 = 3'd0;
   localparam logic [2:0] CSR_ROW0_C23 = 3'd1;
   localparam logic [2:0] CSR_ROW1_C01 = 3'd2;
   localparam logic [2:0] CSR_ROW1_C23 = 3'd3;
   localparam logic [2:0] CSR_ROW2_C01 = 3'd4;
   localparam logic [2:0] CSR_ROW2_C23 = 3'd5;

   localparam logic [31:0] Q_MAX_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MAX_NEG = 32'h8000_0000;

   typedef struct packed {
      logic signed [65:0] n0;
      logic signed [65:0] n1;
      logic signed [65:0] d;
   } dot_type;

   typedef struct packed {
      logic [63:0] dmag;
      logic [63:0] rem_u;
      logic [63:0] rem_v;
      logic [32:0] qn_u;    // dividend bits still to shift out, quotient bits shift in
      logic [32:0] qn_v;
      logic        neg_u;
      logic        neg_v;
      logic        ovf_u;
      logic        ovf_v;
      logic        zero;
   } div_type;

endpackage

// ===== src/ppp_dot.sv =====
// ----------------------------------------------------------------------------
// ppp_dot
// Three row dot products with w = 1: multiply, pair add, final add.
// ----------------------------------------------------------------------------
module ppp_dot
   import ppp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [5:0][63:0]      coef,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [31:0]    x_coord,
   input  logic signed [31:0]    y_coord,
   input  logic signed [31:0]    z_coord,
   output logic                  out_valid,
   input  logic                  out_ready,
   output dot_type               out_data
);

   logic signed [2:0][2:0][63:0] prod_ff, prod_in;
   logic signed [2:0][47:0]      wterm_ff, wterm_in;
   logic signed [2:0][64:0]      pa_ff, pa_in, pb_ff, pb_in;
   dot_type                      sum_ff, sum_in;
   logic                         v1_ff, v2_ff, v3_ff;
   logic                         r1, r2, r3;

   assign r3       = !v3_ff || out_ready;
   assign r2       = !v2_ff || r3;
   assign r1       = !v1_ff || r2;
   assign in_ready = r1;

   // element selects of packed arrays are unsigned: re-sign before widening
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         prod_in[r][0] = $signed(coef[2*r][31:0])    * x_coord;
         prod_in[r][1] = $signed(coef[2*r][63:32])   * y_coord;
         prod_in[r][2] = $signed(coef[2*r+1][31:0])  * z_coord;
         wterm_in[r]   = {coef[2*r+1][63:32], 16'h0000};
         pa_in[r] = 65'($signed(prod_ff[r][0])) + 65'($signed(prod_ff[r][1]));
         pb_in[r] = 65'($signed(prod_ff[r][2])) + 65'($signed(wterm_ff[r]));
      end
      sum_in.n0 = 66'($signed(pa_ff[0])) + 66'($signed(pb_ff[0]));
      sum_in.n1 = 66'($signed(pa_ff[1])) + 66'($signed(pb_ff[1]));
      sum_in.d  = 66'($signed(pa_ff[2])) + 66'($signed(pb_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r1) begin
         prod_ff  <= prod_in;
         wterm_ff <= wterm_in;
      end
      if (r2) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
      if (r3) sum_ff <= sum_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = sum_ff;

endmodule

// ===== src/ppp_prep.sv =====
// ----------------------------------------------------------------------------
// ppp_prep
// Magnitudes and signs, then overflow check and divider seed.
// ----------------------------------------------------------------------------
module ppp_prep
   import ppp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  dot_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   logic [63:0]  mu_ff, mv_ff, md_ff;
   logic [65:0]  au, av, ad;
   logic         nu_ff, nv_ff, z_ff;
   logic         va_ff, vb_ff, ra, rb;
   div_type      seed_ff, seed_in;

   assign rb       = !vb_ff || out_ready;
   assign ra       = !va_ff || rb;
   assign in_ready = ra;

   // magnitudes stay below 2^64
   assign au = in_data.n0[65] ? 66'(-in_data.n0) : 66'(in_data.n0);
   assign av = in_data.n1[65] ? 66'(-in_data.n1) : 66'(in_data.n1);
   assign ad = in_data.d[65]  ? 66'(-in_data.d)  : 66'(in_data.d);

   always_comb begin
      seed_in.dmag  = md_ff;
      seed_in.rem_u = {17'h0, mu_ff[63:17]};
      seed_in.rem_v = {17'h0, mv_ff[63:17]};
      seed_in.qn_u  = {mu_ff[16:0], 16'h0000};
      seed_in.qn_v  = {mv_ff[16:0], 16'h0000};
      seed_in.neg_u = nu_ff;
      seed_in.neg_v = nv_ff;
      // quotient would reach 2^33
      seed_in.ovf_u = {17'h0, mu_ff[63:17]} >= md_ff;
      seed_in.ovf_v = {17'h0, mv_ff[63:17]} >= md_ff;
      seed_in.zero  = z_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (ra) va_ff <= in_valid;
         if (rb) vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ra) begin
         mu_ff <= au[63:0];
         mv_ff <= av[63:0];
         md_ff <= ad[63:0];
         nu_ff <= in_data.n0[65] ^ in_data.d[65];
         nv_ff <= in_data.n1[65] ^ in_data.d[65];
         z_ff  <= (in_data.d == '0);
      end
      if (rb) seed_ff <= seed_in;
   end

   assign out_valid = vb_ff;
   assign out_data  = seed_ff;

endmodule

// ===== src/ppp_div_step.sv =====
// ----------------------------------------------------------------------------
// ppp_div_step
// One restoring division step for both quotients.
// ----------------------------------------------------------------------------
module ppp_div_step
   import ppp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   logic [64:0] ru, rv, du, dv;
   logic        gu, gv;
   div_type     st_ff, st_in;
   logic        v_ff;

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      ru = {in_data.rem_u, in_data.qn_u[32]};
      rv = {in_data.rem_v, in_data.qn_v[32]};
      gu = ru >= {1'b0, in_data.dmag};
      gv = rv >= {1'b0, in_data.dmag};
      du = ru - {1'b0, in_data.dmag};
      dv = rv - {1'b0, in_data.dmag};
      st_in       = in_data;
      st_in.rem_u = gu ? du[63:0] : ru[63:0];
      st_in.rem_v = gv ? dv[63:0] : rv[63:0];
      st_in.qn_u  = {in_data.qn_u[31:0], gu};
      st_in.qn_v  = {in_data.qn_v[31:0], gv};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) st_ff <= st_in;
   end

   assign out_valid = v_ff;
   assign out_data  = st_ff;

endmodule

// ===== src/pinhole_point_projector.sv =====
// ----------------------------------------------------------------------------
// pinhole_point_projector
// Projects Q16.16 world points through a 3x4 camera matrix to image u, v.
// One request per cycle enters and one result per cycle leaves while rsp_stall
// is low. Requests pass through the dot products (multiply, pair add, final
// add), magnitudes and the overflow check, the pipelined restoring divider
// (one quotient bit per stage, u and v in parallel), and sign and saturation
// into the output register. Each stage holds its request only while the stage
// after it is full and stalled, so bubbles are squeezed out and requests keep
// flowing while a result waits. Write the six matrix registers only while the
// pipeline is empty.
// ----------------------------------------------------------------------------
`include "pinhole_point_projector_defines.svh"

module pinhole_point_projector
   import ppp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_addr,
   input  logic [63:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_x_coord,
   input  logic signed [31:0] req_y_coord,
   input  logic signed [31:0] req_z_coord,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_u_coord,
   output logic signed [31:0] rsp_v_coord,
   output logic               rsp_zero_denominator,
   output logic               rsp_saturated
);

   // matrix coefficients, two per register
   logic [5:0][63:0] cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_ROW0_C01: cfg_ff[0] <= csr_wdata;
            CSR_ROW0_C23: cfg_ff[1] <= csr_wdata;
            CSR_ROW1_C01: cfg_ff[2] <= csr_wdata;
            CSR_ROW1_C23: cfg_ff[3] <= csr_wdata;
            CSR_ROW2_C01: cfg_ff[4] <= csr_wdata;
            CSR_ROW2_C23: cfg_ff[5] <= csr_wdata;
            default: ;   // index out of range: ignored
         endcase
      end
   end

   // dot products
   dot_type dot_d;
   logic    dot_v, dot_r, req_ready;

   ppp_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .coef      (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .x_coord   (req_x_coord),
      .y_coord   (req_y_coord),
      .z_coord   (req_z_coord),
      .out_valid (dot_v),
      .out_ready (dot_r),
      .out_data  (dot_d)
   );

   assign req_stall = !req_ready;

   // divider chain: stage 0 is the seed, stage DIV_STEPS the finished quotient
   div_type stg_d [0:DIV_STEPS];
   logic    stg_v [0:DIV_STEPS];
   logic    stg_r [0:DIV_STEPS];

   ppp_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dot_v),
      .in_ready  (dot_r),
      .in_data   (dot_d),
      .out_valid (stg_v[0]),
      .out_ready (stg_r[0]),
      .out_data  (stg_d[0])
   );

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      ppp_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_v[k]),
         .in_ready  (stg_r[k]),
         .in_data   (stg_d[k]),
         .out_valid (stg_v[k+1]),
         .out_ready (stg_r[k+1]),
         .out_data  (stg_d[k+1])
      );
   end

   // sign, saturation and zero-denominator handling
   div_type     fin;
   logic [31:0] u_in, v_in;
   logic        sat_u, sat_v;
   logic [31:0] u_ff, v_ff;
   logic        zd_ff, sat_ff, out_v_ff;
   logic        out_ready;

   assign fin       = stg_d[DIV_STEPS];
   assign out_ready = !out_v_ff || !rsp_stall;
   assign stg_r[DIV_STEPS] = out_ready;

   always_comb begin
      if (fin.neg_u) begin
         sat_u = fin.ovf_u || (fin.qn_u > {1'b0, Q_MAX_NEG});
         u_in  = sat_u ? Q_MAX_NEG : 32'(-fin.qn_u[31:0]);
      end else begin
         sat_u = fin.ovf_u || fin.qn_u[32] || fin.qn_u[31];
         u_in  = sat_u ? Q_MAX_POS : fin.qn_u[31:0];
      end
      if (fin.neg_v) begin
         sat_v = fin.ovf_v || (fin.qn_v > {1'b0, Q_MAX_NEG});
         v_in  = sat_v ? Q_MAX_NEG : 32'(-fin.qn_v[31:0]);
      end else begin
         sat_v = fin.ovf_v || fin.qn_v[32] || fin.qn_v[31];
         v_in  = sat_v ? Q_MAX_POS : fin.qn_v[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_ready) begin
         out_v_ff <= stg_v[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         u_ff   <= fin.zero ? 32'h0 : u_in;
         v_ff   <= fin.zero ? 32'h0 : v_in;
         zd_ff  <= fin.zero;
         sat_ff <= !fin.zero && (sat_u || sat_v);
      end
   end

   assign rsp_valid            = out_v_ff;
   assign rsp_u_coord          = u_ff;
   assign rsp_v_coord          = v_ff;
   assign rsp_zero_denominator = zd_ff;
   assign rsp_saturated        = sat_ff;

   // zero denominator gives a clean all-zero result
   `PPP_ASSERT_NOW(a_zero_den, clock, reset, rsp_valid && rsp_zero_denominator, rsp_u_coord == 32'sd0 && rsp_v_coord == 32'sd0 && !rsp_saturated)
   // a clamped result carries a rail value on u or v
   `PPP_ASSERT_NOW(a_sat_rail, clock, reset, rsp_valid && rsp_saturated, rsp_u_coord == Q_MAX_POS || rsp_u_coord == Q_MAX_NEG || rsp_v_coord == Q_MAX_POS || rsp_v_coord == Q_MAX_NEG)
   // writes beyond the register list leave the matrix alone
   `PPP_ASSERT_NEXT(a_csr_ignore, clock, reset, csr_we && csr_addr > CSR_ROW2_C23, $stable(cfg_ff))

endmodule

// ===== tb/pinhole_point_projector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_point_projector_tb
// Self-checking bench for the 3x4 pinhole projector: a matrix predictor
// computes u, v and flags for each accepted request, a scoreboard compares
// results in order, and the run sweeps several matrices and idle patterns.
// ----------------------------------------------------------------------------
module pinhole_point_projector_tb
   import ppp_pkg::*;
();

   localparam int LATENCY = 39;

   typedef struct {
      logic signed [31:0] u;
      logic signed [31:0] v;
      logic               zden;
      logic               sat;
   } proj_type;

   // ------------------------------------------------------------------------
   // projection predictor and in-order result store
   // ------------------------------------------------------------------------
   class proj_scoreboard;
      logic [63:0] matrix[NUM_CSR];
      proj_type    pending[$];
      int          errors;
      int          checked;

      function void write_reg(logic [2:0] idx, logic [63:0] val);
         if (idx < NUM_CSR) matrix[idx] = val;
      endfunction

      // exact row dot product with w = 1.0
      function logic signed [127:0] row_sum(int row, logic signed [31:0] x,
                                            logic signed [31:0] y,
                                            logic signed [31:0] z);
         logic signed [127:0] c0, c1, c2, c3;
         c0 = $signed(matrix[2*row][31:0]);
         c1 = $signed(matrix[2*row][63:32]);
         c2 = $signed(matrix[2*row+1][31:0]);
         c3 = $signed(matrix[2*row+1][63:32]);
         return c0 * 128'(x) + c1 * 128'(y) + c2 * 128'(z) + c3 * 128'sd65536;
      endfunction

      // Q16.16 quotient, truncated toward zero, clamped
      function logic [31:0] divide(logic signed [127:0] num,
                                   logic signed [127:0] den, ref logic sat);
         logic [127:0] nmag, dmag, q;
         logic         neg;
         nmag = num < 0 ? -num : num;
         dmag = den < 0 ? -den : den;
         q = (nmag << 16) / dmag;
         neg = (num < 0) != (den < 0);
         if (neg) begin
            if (q > 128'h8000_0000) begin
               sat = 1'b1;
               return Q_MAX_NEG;
            end
            return 32'(-q);
         end
         if (q > 128'h7FFF_FFFF) begin
            sat = 1'b1;
            return Q_MAX_POS;
         end
         return q[31:0];
      endfunction

      function void note_request(logic signed [31:0] x, logic signed [31:0] y,
                                 logic signed [31:0] z);
         logic signed [127:0] n0, n1, d;
         proj_type e;
         n0 = row_sum(0, x, y, z);
         n1 = row_sum(1, x, y, z);
         d  = row_sum(2, x, y, z);
         e.sat = 1'b0;
         if (d == 0) begin
            e.u = '0;
            e.v = '0;
            e.zden = 1'b1;
         end else begin
            e.zden = 1'b0;
            e.u = divide(n0, d, e.sat);
            e.v = divide(n1, d, e.sat);
         end
         pending.insert(pending.size(), e);
      endfunction

      function void check_result(proj_type got);
         proj_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result u=%h v=%h", $time, got.u, got.v);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (got.u !== e.u) begin
            $display("%0t: u mismatch exp %h got %h", $time, e.u, got.u);
            errors++;
         end
         if (got.v !== e.v) begin
            $display("%0t: v mismatch exp %h got %h", $time, e.v, got.v);
            errors++;
         end
         if (got.zden !== e.zden) begin
            $display("%0t: zero_denominator mismatch exp %b got %b", $time,
                     e.zden, got.zden);
            errors++;
         end
         if (got.sat !== e.sat) begin
            $display("%0t: saturated mismatch exp %b got %b", $time, e.sat,
                     got.sat);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_addr = '0;
   logic [63:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_x_coord = '0;
   logic signed [31:0] req_y_coord = '0;
   logic signed [31:0] req_z_coord = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_u_coord;
   logic signed [31:0] rsp_v_coord;
   logic               rsp_zero_denominator;
   logic               rsp_saturated;

   proj_scoreboard sb = new();
   int send_idle_pct = 0;    // sender gap chance, percent
   int stall_pct = 0;        // receiver stall chance, percent
   int sent = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   pinhole_point_projector i_dut (.*);

   // results are sampled at the rising edge
   always @(posedge clock) begin
      proj_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.u = rsp_u_coord;
         got.v = rsp_v_coord;
         got.zden = rsp_zero_denominator;
         got.sat = rsp_saturated;
         sb.check_result(got);
      end
   end

   // receiver stalls, changed at the falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // write enable is dropped by the caller after the last register
   task automatic write_matrix_reg(logic [2:0] idx, logic [63:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
   endtask

   // one request; valid stays high into the next request if no gap follows
   task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      req_z_coord <= z;
      do @(posedge clock); while (req_stall);
      sb.note_request(x, y, z);
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($signed($urandom_range(2000)) - 1000);
         3: return '0;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] rand_point();
      case ($urandom_range(5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($signed($urandom_range(20)) - 10) << 16;
         default: return $urandom();
      endcase
   endfunction

   task automatic load_matrix(logic [31:0] c[12]);
      for (int r = 0; r < NUM_CSR; r++)
         write_matrix_reg(r[2:0], {c[2*r+1], c[2*r]});
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [31:0] c[12];
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: identity-like camera, d = z
      c = '{32'h1_0000, 0, 0, 0, 0, 32'h1_0000, 0, 0, 0, 0, 32'h1_0000, 0};
      load_matrix(c);
      send_point(32'h0002_0000, 32'hFFFD_0000, 32'h0001_0000);  // plain
      send_point(32'h0003_0000, 32'h0001_0000, 32'hFFFE_0000);  // negative d
      send_point(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);  // zero d
      send_point(32'h0007_0000, 32'h0001_0000, 32'h0003_0000);  // truncation
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);  // both clamp
      send_point(32'h7FFF_FFFF, 32'h0, 32'h0001_0000);          // exact max
      send_point(32'h8000_0000, 32'h0, 32'h0001_0000);          // exact min
      send_point(32'h8000_0000, 32'h0, 32'hFFFF_0000);          // +2^31 clamps
      send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF);  // near zero
      drain();
      // extreme coefficients everywhere
      foreach (c[i]) c[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      load_matrix(c);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
      send_point(32'h0, 32'h0, 32'h0);
      drain();

      // Random phases over matrices and idle patterns
      for (int ph = 0; ph < 8; ph++) begin
         foreach (c[i]) c[i] = rand_coef();
         if (ph == 3) for (int i = 8; i < 12; i++) c[i] = '0;  // d always zero
         load_matrix(c);
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 72; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 72; end
            default: begin send_idle_pct = 36; stall_pct = 36; end
         endcase
         for (int n = 0; n < 130; n++)
            send_point(rand_point(), rand_point(), rand_point());
         drain();
      end
      send_idle_pct = 0;
      stall_pct = 0;

      $display("Covered %0d requests, %0d results checked over 10 matrices",
               sent, sb.checked);
      $display("and four sender/receiver idle mixes.");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/ppp_pkg.sv
src/ppp_dot.sv
src/ppp_prep.sv
src/ppp_div_step.sv
src/pinhole_point_projector.sv
tb/pinhole_point_projector_tb.sv
